// ===== design/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, kind codes and attribute bit masks for the short-descriptor
// codec.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // descriptor kinds
  localparam logic [2:0] KIND_TABLE   = 3'd0;
  localparam logic [2:0] KIND_SECTION = 3'd1;
  localparam logic [2:0] KIND_SUPER   = 3'd2;
  localparam logic [2:0] KIND_LARGE   = 3'd3;
  localparam logic [2:0] KIND_SMALL   = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  // commands
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // configuration register indexes
  localparam logic CFG_MULTICORE_SHARED = 1'b0;
  localparam logic CFG_PRIV_NEVER_EXEC  = 1'b1;

  // permission bits
  localparam logic [5:0] PERM_PR = 6'h01;
  localparam logic [5:0] PERM_PW = 6'h02;
  localparam logic [5:0] PERM_PX = 6'h04;
  localparam logic [5:0] PERM_UR = 6'h08;
  localparam logic [5:0] PERM_UW = 6'h10;
  localparam logic [5:0] PERM_UX = 6'h20;

  typedef struct packed {
    logic        command;
    logic [1:0]  level;
    logic [31:0] word;
    logic        valid_block;
    logic        is_table;
    logic        secure;
    logic        global_req;
    logic [5:0]  permissions;
    logic [2:0]  memory_type;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_word;
    logic        out_valid_block;
    logic        out_table;
    logic        out_secure;
    logic        out_global;
    logic [5:0]  out_permissions;
    logic [2:0]  out_memory_type;
  } rsp_t;

  typedef struct packed {
    logic multicore_shared;
    logic privileged_never_execute;
  } cfg_t;

endpackage

// ===== design/sdc_req_if.sv =====
// ----------------------------------------------------------------------------
// sdc_req_if
// Request channel: command, level, descriptor or address and attributes.
// ----------------------------------------------------------------------------
interface sdc_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  level;
  logic [31:0] word;
  logic        valid_block;
  logic        is_table;
  logic        secure;
  logic        global_req;
  logic [5:0]  permissions;
  logic [2:0]  memory_type;

  modport source (
    output valid, command, level, word, valid_block, is_table, secure,
           global_req, permissions, memory_type,
    input  ready
  );
  modport sink (
    input  valid, command, level, word, valid_block, is_table, secure,
           global_req, permissions, memory_type,
    output ready
  );
endinterface

// ===== design/sdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sdc_rsp_if
// Result channel: kind, result word and decoded attributes.
// ----------------------------------------------------------------------------
interface sdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] result_word;
  logic        out_valid_block;
  logic        out_table;
  logic        out_secure;
  logic        out_global;
  logic [5:0]  out_permissions;
  logic [2:0]  out_memory_type;

  modport source (
    output valid, kind, result_word, out_valid_block, out_table, out_secure,
           out_global, out_permissions, out_memory_type,
    input  ready
  );
  modport sink (
    input  valid, kind, result_word, out_valid_block, out_table, out_secure,
           out_global, out_permissions, out_memory_type,
    output ready
  );
endinterface

// ===== design/sdc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sdc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdc_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/sdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sdc_cfg_regs
// Configuration register file; always ready for a write.
// ----------------------------------------------------------------------------
module sdc_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  sdc_cfg_if.sink         cfg,
  output sdc_pkg::cfg_t   regs
);

  sdc_pkg::cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg.index)
        sdc_pkg::CFG_MULTICORE_SHARED: regs_next.multicore_shared = cfg.data;
        sdc_pkg::CFG_PRIV_NEVER_EXEC:  regs_next.privileged_never_execute = cfg.data;
        default:                       regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.multicore_shared         <= 1'b1;
      regs.privileged_never_execute <= 1'b0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

// ===== design/sdc_decode.sv =====
// ----------------------------------------------------------------------------
// sdc_decode
// Classify a short-format descriptor, mask its address and pull out the
// attributes of tables, sections and small pages.
// ----------------------------------------------------------------------------
module sdc_decode (
  input  sdc_pkg::req_t req,
  output sdc_pkg::rsp_t rsp
);

  logic        first;
  logic [31:0] w;
  logic [2:0]  kind;
  logic [31:0] mask;
  logic [5:0]  perm;

  assign first = (req.level == 2'd1);
  assign w     = req.word;

  always_comb begin
    kind = sdc_pkg::KIND_INVALID;
    if (first) begin
      if (w[1:0] == 2'b01) begin
        kind = sdc_pkg::KIND_TABLE;
      end else if (w[1]) begin
        kind = w[18] ? sdc_pkg::KIND_SUPER : sdc_pkg::KIND_SECTION;
      end
    end else begin
      if (w[1:0] == 2'b01) begin
        kind = sdc_pkg::KIND_LARGE;
      end else if (w[1]) begin
        kind = sdc_pkg::KIND_SMALL;
      end
    end
  end

  always_comb begin
    case (kind)
      sdc_pkg::KIND_TABLE:   mask = 32'hFFFF_FC00;
      sdc_pkg::KIND_SECTION: mask = 32'hFFF0_0000;
      sdc_pkg::KIND_SUPER:   mask = 32'hFF00_0000;
      sdc_pkg::KIND_LARGE:   mask = 32'hFFFF_0000;
      sdc_pkg::KIND_SMALL:   mask = 32'hFFFF_F000;
      default:               mask = 32'hFFFF_FFF0;
    endcase
  end

  always_comb begin
    perm                = '0;
    rsp                 = '0;
    rsp.kind            = kind;
    rsp.result_word     = w & mask;
    case (kind)
      sdc_pkg::KIND_TABLE: begin
        rsp.out_table  = 1'b1;
        rsp.out_secure = ~w[3];
      end
      sdc_pkg::KIND_SECTION: begin
        if (w[10]) begin
          perm = perm | sdc_pkg::PERM_PR | sdc_pkg::PERM_PX | sdc_pkg::PERM_UR
               | sdc_pkg::PERM_UX;
        end
        if (!w[15]) perm = perm | sdc_pkg::PERM_PW | sdc_pkg::PERM_UW;
        if (w[4]) perm = perm & ~(sdc_pkg::PERM_PX | sdc_pkg::PERM_UX);
        if (w[0]) perm = perm & ~sdc_pkg::PERM_PX;
        rsp.out_valid_block = 1'b1;
        rsp.out_permissions = perm;
        rsp.out_memory_type = w[14:12] | {1'b0, w[3:2]};
        rsp.out_global      = ~w[17];
        rsp.out_secure      = ~w[19];
      end
      sdc_pkg::KIND_SMALL: begin
        if (w[4]) begin
          perm = perm | sdc_pkg::PERM_PR | sdc_pkg::PERM_PX | sdc_pkg::PERM_UR
               | sdc_pkg::PERM_UX;
        end
        if (!w[9]) perm = perm | sdc_pkg::PERM_PW | sdc_pkg::PERM_UW;
        if (w[0]) perm = perm & ~(sdc_pkg::PERM_PX | sdc_pkg::PERM_UX);
        rsp.out_valid_block = 1'b1;
        rsp.out_permissions = perm;
        rsp.out_memory_type = w[8:6] | {1'b0, w[3:2]};
        rsp.out_global      = ~w[11];
      end
      default: begin
        rsp.out_permissions = '0;
      end
    endcase
  end

endmodule

// ===== design/sdc_encode.sv =====
// ----------------------------------------------------------------------------
// sdc_encode
// Widen requested permissions and build a table, section or small-page
// descriptor, then merge in the physical address.
// ----------------------------------------------------------------------------
module sdc_encode (
  input  sdc_pkg::req_t req,
  input  sdc_pkg::cfg_t cfg,
  output sdc_pkg::rsp_t rsp
);

  logic        first;
  logic [5:0]  a;
  logic [31:0] d;
  logic [2:0]  kind;
  logic [2:0]  tc;

  assign first = (req.level == 2'd1);
  assign tc    = req.memory_type;

  // user read or write implies the privileged one; write or execute implies read
  always_comb begin
    a = req.permissions;
    if ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_PW)) != '0) a = a | sdc_pkg::PERM_PR;
    if ((a & (sdc_pkg::PERM_UX | sdc_pkg::PERM_UW)) != '0) a = a | sdc_pkg::PERM_UR;
    if ((a & sdc_pkg::PERM_UR) != '0) a = a | sdc_pkg::PERM_PR;
    if ((a & sdc_pkg::PERM_UW) != '0) a = a | sdc_pkg::PERM_PW;
  end

  always_comb begin
    d    = '0;
    kind = sdc_pkg::KIND_INVALID;
    if (first && req.is_table) begin
      kind = sdc_pkg::KIND_TABLE;
      d[0] = 1'b1;
      d[3] = ~req.secure;
    end else if (!req.valid_block) begin
      kind = sdc_pkg::KIND_INVALID;
    end else if (first) begin
      kind  = sdc_pkg::KIND_SECTION;
      d[1]  = 1'b1;
      d[16] = cfg.multicore_shared;
      d[4]  = ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_UX)) == '0);
      d[0]  = cfg.privileged_never_execute && ((a & sdc_pkg::PERM_PX) == '0);
      d[11] = ((a & sdc_pkg::PERM_UR) != '0);
      d[15] = ((a & sdc_pkg::PERM_PW) == '0);
      d[10] = ((a & (sdc_pkg::PERM_UR | sdc_pkg::PERM_PR)) != '0);
      d[17] = ~req.global_req;
      d[19] = ~req.secure;
      d[12] = tc[2];
      d[3]  = tc[1];
      d[2]  = tc[0];
    end else begin
      kind  = sdc_pkg::KIND_SMALL;
      d[1]  = 1'b1;
      d[10] = cfg.multicore_shared;
      d[0]  = ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_UX)) == '0);
      d[5]  = ((a & sdc_pkg::PERM_UR) != '0);
      d[9]  = ((a & sdc_pkg::PERM_PW) == '0);
      d[4]  = ((a & (sdc_pkg::PERM_UR | sdc_pkg::PERM_PR)) != '0);
      d[11] = ~req.global_req;
      d[6]  = tc[2];
      d[3]  = tc[1];
      d[2]  = tc[0];
    end
  end

  always_comb begin
    rsp             = '0;
    rsp.kind        = kind;
    rsp.result_word = d | req.word;
  end

endmodule

// ===== design/short_descriptor_codec.sv =====
// ----------------------------------------------------------------------------
// short_descriptor_codec
// Two-way codec between 32-bit short-format translation descriptors and
// abstract memory attributes.
// ----------------------------------------------------------------------------
// A request is captured in an input register, decoded or encoded by a single
// pass of bit-field logic, and the result lands in an output register. One
// request is taken every cycle while the result side is not stalled, and a
// stalled result holds both registers while the input register still frees
// up as soon as the result register does. Configuration writes are taken at
// any time but should only be issued while no request is in flight; the
// registers are read when a request moves into the result register. Decode
// masks the address by kind and reports attributes for tables, sections and
// small pages only; encode reports kind and descriptor with zero attributes.
// A level other than one is treated as the second level.
// ----------------------------------------------------------------------------
module short_descriptor_codec (
  input  logic     clk,
  input  logic     rst,
  sdc_req_if.sink  req,
  sdc_rsp_if.source rsp,
  sdc_cfg_if.sink  cfg
);

  sdc_pkg::cfg_t regs;
  sdc_pkg::req_t in_req;
  sdc_pkg::req_t s1_req;
  logic          s1_valid;
  sdc_pkg::rsp_t dec_rsp;
  sdc_pkg::rsp_t enc_rsp;
  sdc_pkg::rsp_t rsp_next;
  sdc_pkg::rsp_t rsp_q;
  logic          rsp_valid;
  logic          advance;

  sdc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // gather the request payload
  always_comb begin
    in_req.command     = req.command;
    in_req.level       = req.level;
    in_req.word        = req.word;
    in_req.valid_block = req.valid_block;
    in_req.is_table    = req.is_table;
    in_req.secure      = req.secure;
    in_req.global_req  = req.global_req;
    in_req.permissions = req.permissions;
    in_req.memory_type = req.memory_type;
  end

  // result register moves when empty or drained this cycle
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  // input register: hold while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req <= in_req;
    end
  end

  sdc_decode u_dec (
    .req (s1_req),
    .rsp (dec_rsp)
  );

  sdc_encode u_enc (
    .req (s1_req),
    .cfg (regs),
    .rsp (enc_rsp)
  );

  assign rsp_next = (s1_req.command == sdc_pkg::CMD_ENCODE) ? enc_rsp : dec_rsp;

  // result register: advance when empty or when the sink takes the current result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.kind            = rsp_q.kind;
  assign rsp.result_word     = rsp_q.result_word;
  assign rsp.out_valid_block = rsp_q.out_valid_block;
  assign rsp.out_table       = rsp_q.out_table;
  assign rsp.out_secure      = rsp_q.out_secure;
  assign rsp.out_global      = rsp_q.out_global;
  assign rsp.out_permissions = rsp_q.out_permissions;
  assign rsp.out_memory_type = rsp_q.out_memory_type;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !rsp_valid))
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request lost from input register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req.ready)
    else $error("input stalled with empty result register");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_q.kind <= sdc_pkg::KIND_INVALID))
    else $error("result kind out of range");

  a_no_attr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_q.kind == sdc_pkg::KIND_SUPER ||
                   rsp_q.kind == sdc_pkg::KIND_LARGE ||
                   rsp_q.kind == sdc_pkg::KIND_INVALID))
    |-> (rsp_q.out_permissions == '0 && rsp_q.out_memory_type == '0 &&
         !rsp_q.out_valid_block && !rsp_q.out_table && !rsp_q.out_secure &&
         !rsp_q.out_global))
    else $error("attributes reported for a kind that carries none");
`endif

endmodule

// ===== tb/tb_short_descriptor_codec.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_short_descriptor_codec
// Self-checking bench for the short-descriptor codec. Directed decode and
// encode requests cover every descriptor kind, level and permission corner.
// Random traffic then runs under every setting of the two configuration
// registers. Every accepted request is predicted in the bench, and each
// result is compared field by field in arrival order. The sender works in
// bursts, the receiver stalls on its own pattern, and one long receiver
// hold-off backs the codec up into its input.
// ----------------------------------------------------------------------------
module tb_short_descriptor_codec;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int LONG_HOLD_LEN  = 80;
  localparam int PHASE_REQUESTS = 215;

  // receiver stall modes
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE
  } rdy_mode_e;

  logic clk;
  logic rst;

  sdc_req_if req_ch ();
  sdc_rsp_if rsp_ch ();
  sdc_cfg_if cfg_ch ();

  short_descriptor_codec u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Bench copy of the configuration registers, reset values.
  sdc_pkg::cfg_t codec_cfg = '{multicore_shared: 1'b1, privileged_never_execute: 1'b0};

  // Results predicted for accepted requests, oldest first.
  sdc_pkg::rsp_t pending_results[$];

  int error_count        = 0;
  int cycle_count        = 0;
  int long_hold_requests = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("short_descriptor_codec test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: decode classifies and masks, encode widens permissions and
  // builds a table, section or small-page descriptor.
  // --------------------------------------------------------------------------
  function automatic sdc_pkg::rsp_t translate_descriptor(input sdc_pkg::req_t r,
                                                         input sdc_pkg::cfg_t c);
    sdc_pkg::rsp_t o;
    logic          first;
    logic [5:0]    a;
    logic [31:0]   d;
    int            sh;
    o     = '0;
    a     = '0;
    d     = '0;
    first = (r.level == 2'd1);
    if (r.command == sdc_pkg::CMD_DECODE) begin
      if (first) begin
        if (r.word[1:0] == 2'b01) o.kind = sdc_pkg::KIND_TABLE;
        else if (r.word[1]) o.kind = r.word[18] ? sdc_pkg::KIND_SUPER : sdc_pkg::KIND_SECTION;
        else o.kind = sdc_pkg::KIND_INVALID;
      end else begin
        if (r.word[1:0] == 2'b01) o.kind = sdc_pkg::KIND_LARGE;
        else if (r.word[1]) o.kind = sdc_pkg::KIND_SMALL;
        else o.kind = sdc_pkg::KIND_INVALID;
      end
      case (o.kind)
        sdc_pkg::KIND_TABLE:   sh = 10;
        sdc_pkg::KIND_SECTION: sh = 20;
        sdc_pkg::KIND_SUPER:   sh = 24;
        sdc_pkg::KIND_LARGE:   sh = 16;
        sdc_pkg::KIND_SMALL:   sh = 12;
        default:               sh = 4;
      endcase
      o.result_word = r.word & ({32{1'b1}} << sh);
      case (o.kind)
        sdc_pkg::KIND_TABLE: begin
          o.out_table  = 1'b1;
          o.out_secure = ~r.word[3];
        end
        sdc_pkg::KIND_SECTION: begin
          o.out_valid_block = 1'b1;
          if (r.word[10]) begin
            a = a | sdc_pkg::PERM_PR | sdc_pkg::PERM_PX | sdc_pkg::PERM_UR | sdc_pkg::PERM_UX;
          end
          if (!r.word[15]) a = a | sdc_pkg::PERM_PW | sdc_pkg::PERM_UW;
          if (r.word[4]) a = a & ~(sdc_pkg::PERM_PX | sdc_pkg::PERM_UX);
          if (r.word[0]) a = a & ~sdc_pkg::PERM_PX;
          o.out_permissions = a;
          o.out_memory_type = r.word[14:12] | {1'b0, r.word[3:2]};
          o.out_global      = ~r.word[17];
          o.out_secure      = ~r.word[19];
        end
        sdc_pkg::KIND_SMALL: begin
          o.out_valid_block = 1'b1;
          if (r.word[4]) begin
            a = a | sdc_pkg::PERM_PR | sdc_pkg::PERM_PX | sdc_pkg::PERM_UR | sdc_pkg::PERM_UX;
          end
          if (!r.word[9]) a = a | sdc_pkg::PERM_PW | sdc_pkg::PERM_UW;
          if (r.word[0]) a = a & ~(sdc_pkg::PERM_PX | sdc_pkg::PERM_UX);
          o.out_permissions = a;
          o.out_memory_type = r.word[8:6] | {1'b0, r.word[3:2]};
          o.out_global      = ~r.word[11];
        end
        default: ;
      endcase
    end else begin
      a = r.permissions;
      if (first && r.is_table) begin
        d      = 32'h1;
        d[3]   = ~r.secure;
        o.kind = sdc_pkg::KIND_TABLE;
      end else if (!r.valid_block) begin
        o.kind = sdc_pkg::KIND_INVALID;
      end else begin
        if ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_PW)) != 0) a = a | sdc_pkg::PERM_PR;
        if ((a & (sdc_pkg::PERM_UX | sdc_pkg::PERM_UW)) != 0) a = a | sdc_pkg::PERM_UR;
        if ((a & sdc_pkg::PERM_UR) != 0) a = a | sdc_pkg::PERM_PR;
        if ((a & sdc_pkg::PERM_UW) != 0) a = a | sdc_pkg::PERM_PW;
        d = 32'h2;
        if (first) begin
          o.kind = sdc_pkg::KIND_SECTION;
          d[16]  = c.multicore_shared;
          d[4]   = ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_UX)) == 0);
          d[0]   = c.privileged_never_execute && ((a & sdc_pkg::PERM_PX) == 0);
          d[11]  = ((a & sdc_pkg::PERM_UR) != 0);
          d[15]  = ((a & sdc_pkg::PERM_PW) == 0);
          d[10]  = ((a & (sdc_pkg::PERM_UR | sdc_pkg::PERM_PR)) != 0);
          d[17]  = ~r.global_req;
          d[19]  = ~r.secure;
          d[12]  = r.memory_type[2];
          d[3]   = r.memory_type[1];
          d[2]   = r.memory_type[0];
        end else begin
          o.kind = sdc_pkg::KIND_SMALL;
          d[10]  = c.multicore_shared;
          d[0]   = ((a & (sdc_pkg::PERM_PX | sdc_pkg::PERM_UX)) == 0);
          d[5]   = ((a & sdc_pkg::PERM_UR) != 0);
          d[9]   = ((a & sdc_pkg::PERM_PW) == 0);
          d[4]   = ((a & (sdc_pkg::PERM_UR | sdc_pkg::PERM_PR)) != 0);
          d[11]  = ~r.global_req;
          d[6]   = r.memory_type[2];
          d[3]   = r.memory_type[1];
          d[2]   = r.memory_type[0];
        end
      end
      o.result_word = d | r.word;
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic sdc_pkg::req_t decode_request(input logic [1:0] lvl,
                                                   input logic [31:0] w);
    sdc_pkg::req_t r;
    r         = '0;
    r.command = sdc_pkg::CMD_DECODE;
    r.level   = lvl;
    r.word    = w;
    return r;
  endfunction

  function automatic sdc_pkg::req_t encode_request(input logic [1:0] lvl,
                                                   input logic [31:0] pa,
                                                   input logic vb, input logic tbl,
                                                   input logic sec, input logic glob,
                                                   input logic [5:0] perm,
                                                   input logic [2:0] mt);
    sdc_pkg::req_t r;
    r             = '0;
    r.command     = sdc_pkg::CMD_ENCODE;
    r.level       = lvl;
    r.word        = pa;
    r.valid_block = vb;
    r.is_table    = tbl;
    r.secure      = sec;
    r.global_req  = glob;
    r.permissions = perm;
    r.memory_type = mt;
    return r;
  endfunction

  function automatic sdc_pkg::req_t random_request();
    sdc_pkg::req_t r;
    int            pick;
    r         = '0;
    r.command = 1'($urandom_range(0, 1));
    // mostly the two real levels, now and then the out-of-range codes
    pick = $urandom_range(0, 9);
    if (pick == 0) r.level = 2'd0;
    else if (pick == 1) r.level = 2'd3;
    else r.level = 2'($urandom_range(1, 2));
    pick = $urandom_range(0, 15);
    if (pick == 0) r.word = 32'h0;
    else if (pick == 1) r.word = 32'hFFFF_FFFF;
    else r.word = $urandom;
    // lean toward valid blocks so encode builds real descriptors
    r.valid_block = ($urandom_range(0, 3) != 0);
    r.is_table    = ($urandom_range(0, 3) == 0);
    r.secure      = 1'($urandom_range(0, 1));
    r.global_req  = 1'($urandom_range(0, 1));
    r.permissions = 6'($urandom_range(0, 63));
    r.memory_type = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the codec takes it; valid stays up
  // so the next call can follow in the very next cycle.
  task automatic issue_request(input sdc_pkg::req_t r);
    req_ch.valid       <= 1'b1;
    req_ch.command     <= r.command;
    req_ch.level       <= r.level;
    req_ch.word        <= r.word;
    req_ch.valid_block <= r.valid_block;
    req_ch.is_table    <= r.is_table;
    req_ch.secure      <= r.secure;
    req_ch.global_req  <= r.global_req;
    req_ch.permissions <= r.permissions;
    req_ch.memory_type <= r.memory_type;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(translate_descriptor(r, codec_cfg));
  endtask

  // Drop valid and sit out a number of cycles.
  task automatic idle_sender(input int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one configuration register; call only with nothing in flight.
  task automatic write_register(input logic idx, input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == sdc_pkg::CFG_MULTICORE_SHARED) codec_cfg.multicore_shared = value;
    else codec_cfg.privileged_never_execute = value;
    @(posedge clk);
  endtask

  // Random requests in bursts of random length with random gaps between.
  task automatic random_bursts(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        issue_request(random_request());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin
    rdy_mode_e     mode;
    int            segment_left;
    int            hold_left;
    int            long_hold_served;
    sdc_pkg::rsp_t want;
    mode             = RDY_ALWAYS;
    segment_left     = 0;
    hold_left        = 0;
    long_hold_served = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // check a result taken at this edge
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding, kind %h word %h",
                   $time, rsp_ch.kind, rsp_ch.result_word);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
          check_field("result_word", want.result_word, rsp_ch.result_word);
          check_field("out_valid_block", 32'(want.out_valid_block),
                      32'(rsp_ch.out_valid_block));
          check_field("out_table", 32'(want.out_table), 32'(rsp_ch.out_table));
          check_field("out_secure", 32'(want.out_secure), 32'(rsp_ch.out_secure));
          check_field("out_global", 32'(want.out_global), 32'(rsp_ch.out_global));
          check_field("out_permissions", 32'(want.out_permissions),
                      32'(rsp_ch.out_permissions));
          check_field("out_memory_type", 32'(want.out_memory_type),
                      32'(rsp_ch.out_memory_type));
        end
      end
      // a long hold-off asked for by a test takes priority over the pattern
      if (long_hold_served != long_hold_requests) begin
        long_hold_served = long_hold_requests;
        hold_left        = LONG_HOLD_LEN;
      end
      if (segment_left == 0) begin
        segment_left = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0:       mode = RDY_ALWAYS;
          1:       mode = RDY_COIN;
          default: mode = RDY_SPARSE;
        endcase
      end
      segment_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS: rsp_ch.ready <= 1'b1;
          RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every descriptor kind at both levels, the all-ones and all-zero words,
  // and the out-of-range level codes that fall back to the second level.
  task automatic test_directed_decode();
    issue_request(decode_request(2'd1, 32'h0000_0001));
    issue_request(decode_request(2'd1, 32'hFFFF_FFF9));
    issue_request(decode_request(2'd1, 32'h0000_0002));
    issue_request(decode_request(2'd1, 32'hFFFB_FFFF));
    issue_request(decode_request(2'd1, 32'h0000_0403));
    issue_request(decode_request(2'd1, 32'hFFFF_FFFF));
    issue_request(decode_request(2'd1, 32'h0000_0000));
    issue_request(decode_request(2'd2, 32'hFFFF_FFFD));
    issue_request(decode_request(2'd2, 32'hFFFF_FFFE));
    issue_request(decode_request(2'd2, 32'h0000_0013));
    issue_request(decode_request(2'd2, 32'hFFFF_FFFC));
    issue_request(decode_request(2'd0, 32'h0000_0002));
    issue_request(decode_request(2'd3, 32'h0000_0001));
    drain_results();
  endtask

  // Tables, invalid entries, sections and small pages, permission widening,
  // a table request at the second level and the fallback level codes.
  task automatic test_directed_encode();
    issue_request(encode_request(2'd1, 32'hFFFF_FC00, 1'b0, 1'b1, 1'b1, 1'b0, 6'h00, 3'd0));
    issue_request(encode_request(2'd1, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 6'h3F, 3'd7));
    issue_request(encode_request(2'd1, 32'h1234_5678, 1'b0, 1'b0, 1'b1, 1'b1, 6'h3F, 3'd7));
    issue_request(encode_request(2'd1, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 6'h00, 3'd0));
    issue_request(encode_request(2'd1, 32'hFFF0_0000, 1'b1, 1'b0, 1'b1, 1'b1, 6'h3F, 3'd7));
    issue_request(encode_request(2'd1, 32'h0010_0000, 1'b1, 1'b0, 1'b1, 1'b0,
                                 sdc_pkg::PERM_UW, 3'd5));
    issue_request(encode_request(2'd1, 32'h0020_0000, 1'b1, 1'b0, 1'b0, 1'b1,
                                 sdc_pkg::PERM_PX, 3'd2));
    issue_request(encode_request(2'd2, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 6'h00, 3'd0));
    issue_request(encode_request(2'd2, 32'hFFFF_F000, 1'b1, 1'b0, 1'b1, 1'b1, 6'h3F, 3'd7));
    issue_request(encode_request(2'd2, 32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0,
                                 sdc_pkg::PERM_UX, 3'd3));
    issue_request(encode_request(2'd2, 32'h0000_2000, 1'b1, 1'b1, 1'b1, 1'b1,
                                 sdc_pkg::PERM_PW, 3'd1));
    issue_request(encode_request(2'd2, 32'h0000_3000, 1'b0, 1'b1, 1'b1, 1'b1, 6'h3F, 3'd4));
    issue_request(encode_request(2'd3, 32'h0000_4000, 1'b1, 1'b0, 1'b1, 1'b0,
                                 sdc_pkg::PERM_UR, 3'd6));
    issue_request(encode_request(2'd0, 32'h0000_5000, 1'b1, 1'b1, 1'b0, 1'b1, 6'h15, 3'd1));
    drain_results();
  endtask

  // Random traffic under every combination of the two registers.
  task automatic test_config_sweep();
    logic [1:0] setting;
    for (int i = 0; i < 4; i++) begin
      // visit 00, 01, 11, 10 so each register toggles both ways
      setting = 2'(i ^ (i >> 1));
      write_register(sdc_pkg::CFG_MULTICORE_SHARED, setting[1]);
      write_register(sdc_pkg::CFG_PRIV_NEVER_EXEC, setting[0]);
      random_bursts(PHASE_REQUESTS);
      drain_results();
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the codec fills and stalls its input.
  task automatic test_backpressure();
    long_hold_requests++;
    repeat (70) issue_request(random_request());
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= sdc_pkg::CMD_DECODE;
    req_ch.level       <= 2'd1;
    req_ch.word        <= '0;
    req_ch.valid_block <= 1'b0;
    req_ch.is_table    <= 1'b0;
    req_ch.secure      <= 1'b0;
    req_ch.global_req  <= 1'b0;
    req_ch.permissions <= '0;
    req_ch.memory_type <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= sdc_pkg::CFG_MULTICORE_SHARED;
    cfg_ch.data        <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_directed_decode();
    test_directed_encode();
    test_config_sweep();
    test_backpressure();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("short_descriptor_codec test passed");
    end else begin
      $display("short_descriptor_codec test failed");
    end
    $finish;
  end

endmodule
